// ===== design/avb_pkg.sv =====
// ---------------------------------------------------------------------------
// Angle between vectors package
// Shared types and constants for the CORDIC angle-between-vectors pipeline.
// ---------------------------------------------------------------------------
package avb_pkg;

  localparam int CORDIC_STAGES  = 16;
  localparam int ATAN_TABLE_LEN = 24;
  localparam int CORDIC_DEPTH   = (CORDIC_STAGES < ATAN_TABLE_LEN) ?
                                  CORDIC_STAGES : ATAN_TABLE_LEN;
  localparam int STAGE_W        = $clog2(ATAN_TABLE_LEN);

  // Datapath width of the rotated vector: components enter as value << 16
  // and grow by the CORDIC gain times sqrt(2).
  localparam int VEC_W = 36;

  localparam logic [31:0] HALF_TURN   = 32'h8000_0000;
  localparam logic [16:0] ANGLE_SCALE = 17'd92160;   // 360 * 256
  localparam logic [31:0] ROUND_HALF  = 32'h8000_0000;

  localparam logic [31:0] MIN_LEN_SQ_RESET = 32'd1;

  // Register index decoded from paddr[2].
  localparam logic REG_MIN_LEN_SQ = 1'b0;

  localparam logic [31:0] ATAN_TURNS [ATAN_TABLE_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic signed [15:0] first_x;
    logic signed [15:0] first_y;
    logic signed [15:0] second_x;
    logic signed [15:0] second_y;
  } vec_pair_t;

  typedef struct packed {
    logic [15:0] angle_degrees;
    logic        degenerate;
  } angle_result_t;

  // One vector in flight through the CORDIC chain.
  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic [31:0]             z;
    logic                    zero;
  } cordic_vec_t;

  typedef struct packed {
    cordic_vec_t a;
    cordic_vec_t b;
    logic        degenerate;
  } cordic_item_t;

endpackage

// ===== design/avb_prep.sv =====
// ---------------------------------------------------------------------------
// Input preparation
// Squared lengths, degenerate test and half-turn pre-rotation, two stages.
// ---------------------------------------------------------------------------
module avb_prep (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    up_valid,
  output logic                    up_ready,
  input  avb_pkg::vec_pair_t      up_data,
  input  logic [31:0]             min_length_squared,
  output logic                    down_valid,
  input  logic                    down_ready,
  output avb_pkg::cordic_item_t   down_data
);
  import avb_pkg::*;

  logic               s1_valid;
  logic               s1_ready;
  cordic_vec_t        s1_a;
  cordic_vec_t        s1_b;
  logic [31:0]        s1_len_a;
  logic [31:0]        s1_len_b;

  logic               s2_valid;
  logic               s2_ready;
  cordic_item_t       s2_data;

  cordic_vec_t        pre_a;
  cordic_vec_t        pre_b;
  logic signed [31:0] sq_ax;
  logic signed [31:0] sq_ay;
  logic signed [31:0] sq_bx;
  logic signed [31:0] sq_by;

  function automatic cordic_vec_t pre_rotate(logic signed [15:0] cx,
                                             logic signed [15:0] cy);
    cordic_vec_t v;
    logic signed [VEC_W-1:0] xs;
    logic signed [VEC_W-1:0] ys;
    xs = {{(VEC_W-32){cx[15]}}, cx, 16'h0000};
    ys = {{(VEC_W-32){cy[15]}}, cy, 16'h0000};
    v.zero = (cx == 16'sd0) && (cy == 16'sd0);
    // A vector in the left half-plane is turned by half a turn first.
    if (cx[15]) begin
      v.x = -xs;
      v.y = -ys;
      v.z = HALF_TURN;
    end else begin
      v.x = xs;
      v.y = ys;
      v.z = 32'h0;
    end
    return v;
  endfunction

  assign pre_a = pre_rotate(up_data.first_x, up_data.first_y);
  assign pre_b = pre_rotate(up_data.second_x, up_data.second_y);
  assign sq_ax = up_data.first_x * up_data.first_x;
  assign sq_ay = up_data.first_y * up_data.first_y;
  assign sq_bx = up_data.second_x * up_data.second_x;
  assign sq_by = up_data.second_y * up_data.second_y;

  assign s2_ready = !s2_valid || down_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign up_ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= up_valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && up_valid) begin
      s1_a     <= pre_a;
      s1_b     <= pre_b;
      s1_len_a <= 32'(sq_ax) + 32'(sq_ay);
      s1_len_b <= 32'(sq_bx) + 32'(sq_by);
    end
    if (s2_ready && s1_valid) begin
      s2_data.a          <= s1_a;
      s2_data.b          <= s1_b;
      s2_data.degenerate <= (s1_len_a < min_length_squared) ||
                            (s1_len_b < min_length_squared);
    end
  end

  assign down_valid = s2_valid;
  assign down_data  = s2_data;

endmodule

// ===== design/avb_cell.sv =====
// ---------------------------------------------------------------------------
// CORDIC vectoring cell
// One micro-rotation of both vectors, registered, with its own valid bit.
// ---------------------------------------------------------------------------
module avb_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [avb_pkg::STAGE_W-1:0]   stage,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  avb_pkg::cordic_item_t         up_data,
  output logic                          down_valid,
  input  logic                          down_ready,
  output avb_pkg::cordic_item_t         down_data
);
  import avb_pkg::*;

  logic         valid;
  cordic_item_t data;
  cordic_item_t data_next;

  function automatic cordic_vec_t rotate(cordic_vec_t v, logic [STAGE_W-1:0] s);
    cordic_vec_t r;
    logic signed [VEC_W-1:0] dx;
    logic signed [VEC_W-1:0] dy;
    logic [31:0]             step;
    dx     = v.y >>> s;
    dy     = v.x >>> s;
    step   = ATAN_TURNS[s];
    r.zero = v.zero;
    // Clockwise when y is non-negative, counterclockwise otherwise.
    if (!v.y[VEC_W-1]) begin
      r.x = v.x + dx;
      r.y = v.y - dy;
      r.z = v.z + step;
    end else begin
      r.x = v.x - dx;
      r.y = v.y + dy;
      r.z = v.z - step;
    end
    return r;
  endfunction

  always_comb begin
    data_next.a          = rotate(up_data.a, stage);
    data_next.b          = rotate(up_data.b, stage);
    data_next.degenerate = up_data.degenerate;
  end

  assign up_ready = !valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data <= data_next;
    end
  end

  assign down_valid = valid;
  assign down_data  = data;

endmodule

// ===== design/avb_post.sv =====
// ---------------------------------------------------------------------------
// Angle output stage
// Direction difference, fold into a half turn and scaling to Q.8 degrees.
// ---------------------------------------------------------------------------
module avb_post (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    up_valid,
  output logic                    up_ready,
  input  avb_pkg::cordic_item_t   up_data,
  output logic                    down_valid,
  input  logic                    down_ready,
  output avb_pkg::angle_result_t  down_data
);
  import avb_pkg::*;

  logic          s1_valid;
  logic          s1_ready;
  logic [31:0]   s1_diff;
  logic          s1_degenerate;

  logic          s2_valid;
  logic          s2_ready;
  angle_result_t s2_data;

  logic [31:0]   dir_a;
  logic [31:0]   dir_b;
  logic [31:0]   diff;
  logic [31:0]   diff_next;
  logic [48:0]   scaled;

  // A zero vector has direction 0 by definition.
  assign dir_a     = up_data.a.zero ? 32'h0 : up_data.a.z;
  assign dir_b     = up_data.b.zero ? 32'h0 : up_data.b.z;
  assign diff      = dir_a - dir_b;
  assign diff_next = (diff > HALF_TURN) ? (32'h0 - diff) : diff;

  assign scaled = 49'(s1_diff) * 49'(ANGLE_SCALE) + 49'(ROUND_HALF);

  assign s2_ready = !s2_valid || down_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign up_ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= up_valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && up_valid) begin
      s1_diff       <= diff_next;
      s1_degenerate <= up_data.degenerate;
    end
    if (s2_ready && s1_valid) begin
      s2_data.angle_degrees <= s1_degenerate ? 16'h0 : scaled[47:32];
      s2_data.degenerate    <= s1_degenerate;
    end
  end

  assign down_valid = s2_valid;
  assign down_data  = s2_data;

endmodule

// ===== design/angle_between_2d_vectors_unit.sv =====
// From input transfer to result, an item passes the preparation stages, the CORDIC cells and the output stages.
// Throughput: one vector pair per cycle unless the output stalls; every cell of
// the CORDIC chain is a pipeline register, and a stage holding a bubble moves even
// while the output stalls. Reset clears all valid bits and sets min_length_squared to 1.
// ---------------------------------------------------------------------------
// Angle between two 2D vectors
// CORDIC vectoring chain giving the unsigned angle between two vectors.
// ---------------------------------------------------------------------------
module angle_between_2d_vectors_unit (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    vec_valid,
  output logic                    vec_ready,
  input  avb_pkg::vec_pair_t      vec_data,
  output logic                    angle_valid,
  input  logic                    angle_ready,
  output avb_pkg::angle_result_t  angle_data,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import avb_pkg::*;

  logic [31:0]  min_length_squared;
  logic         cfg_write;

  logic         chain_valid [CORDIC_DEPTH+1];
  logic         chain_ready [CORDIC_DEPTH+1];
  cordic_item_t chain_data  [CORDIC_DEPTH+1];

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_length_squared <= MIN_LEN_SQ_RESET;
    end else if (cfg_write && (paddr[2] == REG_MIN_LEN_SQ)) begin
      min_length_squared <= pwdata;
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MIN_LEN_SQ: prdata = min_length_squared;
      default:        prdata = 32'h0;
    endcase
  end

  avb_prep u_prep (
    .clk                (clk),
    .rst                (rst),
    .up_valid           (vec_valid),
    .up_ready           (vec_ready),
    .up_data            (vec_data),
    .min_length_squared (min_length_squared),
    .down_valid         (chain_valid[0]),
    .down_ready         (chain_ready[0]),
    .down_data          (chain_data[0])
  );

  for (genvar k = 0; k < CORDIC_DEPTH; k++) begin : g_cell
    avb_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .stage      (STAGE_W'(k)),
      .up_valid   (chain_valid[k]),
      .up_ready   (chain_ready[k]),
      .up_data    (chain_data[k]),
      .down_valid (chain_valid[k+1]),
      .down_ready (chain_ready[k+1]),
      .down_data  (chain_data[k+1])
    );
  end

  avb_post u_post (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (chain_valid[CORDIC_DEPTH]),
    .up_ready   (chain_ready[CORDIC_DEPTH]),
    .up_data    (chain_data[CORDIC_DEPTH]),
    .down_valid (angle_valid),
    .down_ready (angle_ready),
    .down_data  (angle_data)
  );

endmodule

// ===== tb/sv/tb_angle_between_2d_vectors_unit.sv =====
// ---------------------------------------------------------------------------
// Angle between two 2D vectors: self-checking testbench
// Drives vector pairs through the valid/ready input with random gaps, and
// stalls the result channel at random, once for a long stretch so the pipe
// fills up. Every result is compared with the expected value in the directed
// table or with a CORDIC angle predictor kept here. The degeneracy threshold
// is reprogrammed over APB between phases and read back.
// ---------------------------------------------------------------------------
module tb_angle_between_2d_vectors_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CYCLE_LIMIT   = 1_000_000;
  localparam int          DRAIN_CYCLES  = 40;
  localparam int          PRESSURE_AT   = 400;   // result count that starts the hold-off
  localparam int          PRESSURE_HOLD = 500;
  localparam logic [2:0]  ADDR_MIN_LEN_SQ = 3'd0;
  localparam logic [31:0] RESET_MIN_LEN_SQ = 32'd1;

  // Binary angle units: a full turn is 2^32.
  localparam logic [31:0] HALF_TURN_BAM   = 32'h8000_0000;
  localparam logic [63:0] Q8_DEG_PER_TURN = 64'd92160;
  localparam int          ARCTAN_LEN      = 24;
  localparam int          ROT_STAGES      = (avb_pkg::CORDIC_STAGES < ARCTAN_LEN) ?
                                            avb_pkg::CORDIC_STAGES : ARCTAN_LEN;
  localparam logic [31:0] ARCTAN_STEPS [ARCTAN_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic [31:0]            threshold;
    avb_pkg::vec_pair_t     pair;
    logic                   typed;     // result column holds the expected value
    avb_pkg::angle_result_t result;
  } directed_row_t;

  localparam int N_DIRECTED = 24;
  localparam directed_row_t DIRECTED [N_DIRECTED] = '{
    // Degenerate vectors at the reset threshold.
    {32'd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 16'd0, 1'b1},
    {32'd1, 16'sd0, 16'sd0, 16'sd5, 16'sd3, 1'b1, 16'd0, 1'b1},
    {32'd1, 16'sd7, -16'sd2, 16'sd0, 16'sd0, 1'b1, 16'd0, 1'b1},
    // Equal and opposite vectors.
    {32'd1, 16'sd1, 16'sd0, 16'sd1, 16'sd0, 1'b1, 16'd0, 1'b0},
    {32'd1, 16'sd1, 16'sd0, -16'sd1, 16'sd0, 1'b1, 16'd46080, 1'b0},
    {32'd1, 16'sd32767, 16'sd32767, -16'sd32767, -16'sd32767, 1'b1, 16'd46080, 1'b0},
    {32'd1, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1, 16'd0, 1'b0},
    // Axes, quadrants, half-turn start and folding.
    {32'd1, 16'sh8000, 16'sd0, 16'sd32767, 16'sd0, 1'b0, 16'd0, 1'b0},
    {32'd1, 16'sd0, 16'sd1, 16'sd1, 16'sd0, 1'b0, 16'd0, 1'b0},
    {32'd1, 16'sd0, -16'sd1, 16'sd1, 16'sd0, 1'b0, 16'd0, 1'b0},
    {32'd1, 16'sd0, 16'sd32767, 16'sd0, 16'sh8000, 1'b0, 16'd0, 1'b0},
    {32'd1, -16'sd1, 16'sd1, -16'sd1, -16'sd1, 1'b0, 16'd0, 1'b0},
    {32'd1, 16'sd32767, 16'sh8000, 16'sh8000, 16'sd32767, 1'b0, 16'd0, 1'b0},
    {32'd1, 16'sd3, 16'sd4, 16'sd4, 16'sd3, 1'b0, 16'd0, 1'b0},
    {32'd1, 16'sh8000, 16'sd1, 16'sh8000, -16'sd1, 1'b0, 16'd0, 1'b0},
    {32'd1, 16'sd1, -16'sd1, 16'sd1, 16'sd1, 1'b0, 16'd0, 1'b0},
    {32'd1, 16'sd12345, -16'sd23456, -16'sd30000, 16'sd17, 1'b0, 16'd0, 1'b0},
    {32'd1, -16'sd1, 16'sd0, 16'sd0, -16'sd1, 1'b0, 16'd0, 1'b0},
    // Zero threshold: a zero vector points at 0 degrees.
    {32'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 16'd0, 1'b0},
    {32'd0, 16'sd0, 16'sd0, -16'sd1, 16'sd0, 1'b0, 16'd0, 1'b0},
    {32'd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 1'b0, 16'd0, 1'b0},
    // Largest threshold: only the corner vector is long enough.
    {32'h8000_0000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1, 16'd0, 1'b0},
    {32'h8000_0000, 16'sh8000, 16'sh8000, 16'sd32767, 16'sd32767, 1'b1, 16'd0, 1'b1},
    {32'h8000_0000, 16'sd32767, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1, 16'd0, 1'b1}
  };

  logic                   clk;
  logic                   rst         = 1'b1;
  logic                   vec_valid   = 1'b0;
  logic                   vec_ready;
  avb_pkg::vec_pair_t     vec_data    = '0;
  logic                   angle_valid;
  logic                   angle_ready = 1'b0;
  avb_pkg::angle_result_t angle_data;
  logic                   psel        = 1'b0;
  logic                   penable     = 1'b0;
  logic                   pwrite      = 1'b0;
  logic [2:0]             paddr       = ADDR_MIN_LEN_SQ;
  logic [31:0]            pwdata      = '0;
  logic [31:0]            prdata;
  logic                   pready;

  avb_pkg::angle_result_t pending_angles [$];
  logic [31:0]            min_len_sq = RESET_MIN_LEN_SQ;
  int                     error_count = 0;
  int                     results_checked = 0;
  int                     degenerate_seen = 0;
  int                     thresholds_used = 1;
  int                     gapless_left = 0;
  int                     hold_left = 0;

  angle_between_2d_vectors_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .vec_valid   (vec_valid),
    .vec_ready   (vec_ready),
    .vec_data    (vec_data),
    .angle_valid (angle_valid),
    .angle_ready (angle_ready),
    .angle_data  (angle_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Direction of one vector in binary angle units, by CORDIC vectoring.
  function automatic logic [31:0] heading(longint x, longint y);
    logic [31:0] z;
    longint      dx;
    longint      dy;
    z = 32'd0;
    if (x == 0 && y == 0) return 32'd0;
    x = x * 65536;
    y = y * 65536;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = HALF_TURN_BAM;
    end
    for (int i = 0; i < ROT_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx;
        y -= dy;
        z += ARCTAN_STEPS[i];
      end else begin
        x -= dx;
        y += dy;
        z -= ARCTAN_STEPS[i];
      end
    end
    return z;
  endfunction

  function automatic avb_pkg::angle_result_t predict_angle(avb_pkg::vec_pair_t p,
                                                           logic [31:0] floor_sq);
    longint                 ax, ay, bx, by, lim;
    logic [31:0]            d;
    logic [63:0]            scaled;
    avb_pkg::angle_result_t r;
    ax  = longint'(p.first_x);
    ay  = longint'(p.first_y);
    bx  = longint'(p.second_x);
    by  = longint'(p.second_y);
    lim = longint'({32'd0, floor_sq});
    r   = '0;
    if (ax * ax + ay * ay < lim || bx * bx + by * by < lim) begin
      r.degenerate = 1'b1;
      return r;
    end
    // Fold the difference into the upper half-plane, then scale to Q.8 degrees.
    d = heading(ax, ay) - heading(bx, by);
    if (d > HALF_TURN_BAM) d = 32'd0 - d;
    scaled = {32'd0, d} * Q8_DEG_PER_TURN + {32'd0, HALF_TURN_BAM};
    r.angle_degrees = scaled[47:32];
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (gapless_left > 0) begin
      gapless_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      gapless_left = $urandom_range(30, 150);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [15:0] random_component(int extreme_pct, int small_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < extreme_pct) begin
      case ($urandom_range(0, 5))
        0: return 16'sd32767;
        1: return 16'sd0;
        2: return 16'sd1;
        3: return -16'sd1;
        default: return 16'sh8000;
      endcase
    end
    if (r < extreme_pct + small_pct) return 16'(int'($urandom_range(0, 24)) - 12);
    return 16'($urandom);
  endfunction

  function automatic avb_pkg::vec_pair_t random_pair(int extreme_pct, int small_pct);
    avb_pkg::vec_pair_t p;
    int                 rel;
    p.first_x  = random_component(extreme_pct, small_pct);
    p.first_y  = random_component(extreme_pct, small_pct);
    p.second_x = random_component(extreme_pct, small_pct);
    p.second_y = random_component(extreme_pct, small_pct);
    rel = $urandom_range(0, 99);
    if (rel < 8) begin
      p.second_x = p.first_x;
      p.second_y = p.first_y;
    end else if (rel < 16) begin
      p.second_x = -p.first_x;
      p.second_y = -p.first_y;
    end else if (rel < 20) begin
      p.second_x = p.first_y;
      p.second_y = -p.first_x;
    end else if (rel < 24) begin
      p.first_x = 16'sd0;
      p.first_y = 16'sd0;
    end
    return p;
  endfunction

  // Holds the pair on the bus until the transfer, then queues its angle.
  task automatic send_pair(input avb_pkg::vec_pair_t p, input avb_pkg::angle_result_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      vec_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    vec_valid <= 1'b1;
    vec_data  <= p;
    do @(posedge clk); while (!vec_ready);
    pending_angles.push_back(want);
  endtask

  task automatic settle();
    vec_valid <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk);
  endtask

  // Reads the old value, writes the new one and reads it back.
  task automatic program_threshold(input logic [31:0] value);
    logic [31:0] got;
    settle();
    for (int k = 0; k < 3; k++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= (k == 1);
      paddr   <= ADDR_MIN_LEN_SQ;
      pwdata  <= value;
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      got = prdata;
      if (k == 0 && got !== min_len_sq) begin
        $error("min_length_squared readback: expected %0d, got %0d", min_len_sq, got);
        error_count++;
      end
      if (k == 1) min_len_sq = value;
      if (k == 2 && got !== value) begin
        $error("min_length_squared readback: expected %0d, got %0d", value, got);
        error_count++;
      end
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    thresholds_used++;
  endtask

  task automatic run_random(input int count, input int extreme_pct, input int small_pct);
    avb_pkg::vec_pair_t p;
    for (int n = 0; n < count; n++) begin
      p = random_pair(extreme_pct, small_pct);
      send_pair(p, predict_angle(p, min_len_sq));
    end
  endtask

  // Result channel: checks each transfer and drives ready with random stalls.
  initial begin
    avb_pkg::angle_result_t want;
    int                     steady_left;
    int                     r;
    steady_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && angle_valid && angle_ready) begin
        if (pending_angles.size() == 0) begin
          $error("unexpected result: angle_degrees %0d, degenerate %0b",
                 angle_data.angle_degrees, angle_data.degenerate);
          error_count++;
        end else begin
          want = pending_angles.pop_front();
          if (angle_data.angle_degrees !== want.angle_degrees) begin
            $error("angle_degrees mismatch: expected %0d, got %0d",
                   want.angle_degrees, angle_data.angle_degrees);
            error_count++;
          end
          if (angle_data.degenerate !== want.degenerate) begin
            $error("degenerate mismatch: expected %0b, got %0b",
                   want.degenerate, angle_data.degenerate);
            error_count++;
          end
          if (want.degenerate) degenerate_seen++;
        end
        results_checked++;
        // Long hold-off while the sender keeps going, so the pipe backs up.
        if (results_checked == PRESSURE_AT) hold_left = PRESSURE_HOLD;
      end
      if (hold_left > 0) begin
        angle_ready <= 1'b0;
        hold_left--;
      end else if (steady_left > 0) begin
        angle_ready <= 1'b1;
        steady_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 2) begin
          hold_left   = $urandom_range(15, 60);
          angle_ready <= 1'b0;
        end else if (r < 5) begin
          steady_left = $urandom_range(40, 200);
          angle_ready <= 1'b1;
        end else begin
          angle_ready <= (r >= 30);
        end
      end
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding",
             cycles, pending_angles.size());
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int k = 0; k < N_DIRECTED; k++) begin
      if (DIRECTED[k].threshold != min_len_sq) program_threshold(DIRECTED[k].threshold);
      send_pair(DIRECTED[k].pair, DIRECTED[k].typed ? DIRECTED[k].result :
                predict_angle(DIRECTED[k].pair, min_len_sq));
    end

    program_threshold(RESET_MIN_LEN_SQ);
    run_random(700, 10, 10);
    program_threshold(32'd0);
    run_random(300, 25, 40);
    program_threshold($urandom_range(32'h0100_0000, 32'h4000_0000));
    run_random(450, 10, 10);
    program_threshold($urandom_range(2, 150));
    run_random(300, 10, 60);
    program_threshold(32'h8000_0000);
    run_random(250, 90, 0);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d angle transfers, %0d of them degenerate, under %0d thresholds,",
             results_checked, degenerate_seen, thresholds_used);
    $display("with random gaps on both channels and one %0d-cycle result stall.",
             PRESSURE_HOLD);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
